// ===== rtl/esp_pkg.sv =====
package esp_pkg;

   // Sample and average formats
   localparam int SAMPLE_BITS = 12;
   localparam int AVG_BITS    = 28;
   localparam int AVG_FRAC    = AVG_BITS - SAMPLE_BITS;
   localparam int Q8_SHIFT    = AVG_FRAC - 8;

   // Register and result widths
   localparam int ALPHA_BITS     = 17;
   localparam int ALPHA_FRAC     = 16;
   localparam int LIMIT_BITS     = 14;
   localparam int OFFSET_BITS    = 13;
   localparam int CSR_DATA_BITS  = 17;
   localparam int CSR_INDEX_BITS = 2;
   localparam int RESULT_BITS    = 22;

   // Weight multiplier: two weight bits per step
   localparam int DIFF_BITS = AVG_BITS + 1;
   localparam int ACC_BITS  = DIFF_BITS + ALPHA_FRAC + 1;
   localparam int MUL_STEPS = ALPHA_FRAC / 2;

   // Offset reading, wide enough for the biggest average plus offset
   localparam int V_BITS = ((SAMPLE_BITS + 9 > RESULT_BITS) ? SAMPLE_BITS + 9 : RESULT_BITS) + 1;

   // Percent divider
   localparam int SPAN_BITS  = LIMIT_BITS + 1;
   localparam int NUM_BITS   = 22;
   localparam int NUMER_BITS = 30;
   localparam int QUO_BITS   = 15;
   localparam int DIV_STEPS  = QUO_BITS;
   localparam int CNT_BITS   = 4;

   localparam logic [ALPHA_BITS-1:0] ONE_Q16  = ALPHA_BITS'(1 << ALPHA_FRAC);
   localparam logic [QUO_BITS-1:0]   PCT_FULL = QUO_BITS'(25600);

   localparam logic signed [V_BITS-1:0] OUT_MAX = V_BITS'((1 << (RESULT_BITS - 1)) - 1);
   localparam logic signed [V_BITS-1:0] OUT_MIN = -V_BITS'(1 << (RESULT_BITS - 1));

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_EMA_ALPHA      = 2'd0,
      CSR_RANGE_LOW      = 2'd1,
      CSR_RANGE_HIGH     = 2'd2,
      CSR_READING_OFFSET = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic start;
      logic mul_step;
      logic update;
      logic offset;
      logic clamp;
      logic div_load;
      logic div_step;
      logic finish;
   } cmd_type;

endpackage

// ===== rtl/esp_ctrl.sv =====
module esp_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output esp_pkg::cmd_type cmd
);
   import esp_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE,
      S_MUL,
      S_UPDATE,
      S_OFFSET,
      S_CLAMP,
      S_DIV_LOAD,
      S_DIVIDE,
      S_FINISH
   } state_type;

   state_type           state_ff;
   logic [CNT_BITS-1:0] cnt_ff;
   logic                rsp_valid_ff;

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   // Decode commands from the current state
   always_comb begin
      cmd          = '0;
      cmd.start    = (state_ff == S_IDLE) && req_valid;
      cmd.mul_step = (state_ff == S_MUL);
      cmd.update   = (state_ff == S_UPDATE);
      cmd.offset   = (state_ff == S_OFFSET);
      cmd.clamp    = (state_ff == S_CLAMP);
      cmd.div_load = (state_ff == S_DIV_LOAD);
      cmd.div_step = (state_ff == S_DIVIDE);
      cmd.finish   = (state_ff == S_FINISH) && (!rsp_valid_ff || rsp_ready);
   end

   // Sequence one word through multiply, update, scale and divide
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.finish) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end

         unique case (state_ff)
            S_IDLE: begin
               cnt_ff <= '0;
               if (req_valid) begin
                  state_ff <= S_MUL;
               end
            end
            S_MUL: begin
               if (cnt_ff == CNT_BITS'(MUL_STEPS - 1)) begin
                  cnt_ff   <= '0;
                  state_ff <= S_UPDATE;
               end else begin
                  cnt_ff <= cnt_ff + 1'b1;
               end
            end
            S_UPDATE:   state_ff <= S_OFFSET;
            S_OFFSET:   state_ff <= S_CLAMP;
            S_CLAMP:    state_ff <= S_DIV_LOAD;
            S_DIV_LOAD: begin
               cnt_ff   <= '0;
               state_ff <= S_DIVIDE;
            end
            S_DIVIDE: begin
               if (cnt_ff == CNT_BITS'(DIV_STEPS - 1)) begin
                  cnt_ff   <= '0;
                  state_ff <= S_FINISH;
               end else begin
                  cnt_ff <= cnt_ff + 1'b1;
               end
            end
            S_FINISH: begin
               if (cmd.finish) begin
                  state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

endmodule

// ===== rtl/esp_datapath.sv =====
module esp_datapath (
   input  logic                                     clock,
   input  logic                                     reset,
   input  esp_pkg::cmd_type                         cmd,
   input  logic                                     csr_wr_en,
   input  logic [esp_pkg::CSR_INDEX_BITS-1:0]       csr_index,
   input  logic [esp_pkg::CSR_DATA_BITS-1:0]        csr_wdata,
   input  logic [esp_pkg::SAMPLE_BITS-1:0]          req_raw_sample,
   input  logic                                     req_restart_filter,
   output logic signed [esp_pkg::RESULT_BITS-1:0]   rsp_result_q8,
   output logic                                     rsp_is_percent
);
   import esp_pkg::*;

   // Configuration
   logic        [ALPHA_BITS-1:0]  alpha_ff;
   logic signed [LIMIT_BITS-1:0]  low_ff;
   logic signed [LIMIT_BITS-1:0]  high_ff;
   logic signed [OFFSET_BITS-1:0] offset_ff;

   // Filter state and working registers
   logic [AVG_BITS-1:0]          avg_ff;
   logic                         no_avg_ff;
   logic signed [DIFF_BITS-1:0]  diff_ff;
   logic [ALPHA_FRAC-1:0]        mulb_ff;
   logic signed [ACC_BITS-1:0]   acc_ff;
   logic signed [V_BITS-1:0]     v_ff;
   logic [NUM_BITS-1:0]          num_ff;
   logic [SPAN_BITS-1:0]         span_ff;
   logic [QUO_BITS-1:0]          rem_ff;
   logic [QUO_BITS-1:0]          qsh_ff;
   logic signed [RESULT_BITS-1:0] result_ff;
   logic                         is_percent_ff;

   // Next values
   logic [ALPHA_BITS-1:0]         alpha_sat;
   logic                          load;
   logic [AVG_BITS-1:0]           xs;
   logic signed [DIFF_BITS-1:0]   diff_in;
   logic signed [ACC_BITS-1:0]    acc_in;
   logic signed [ACC_BITS-1:0]    acc_rnd;
   logic signed [ACC_BITS-1:0]    corr;
   logic [AVG_BITS-1:0]           avg_in;
   logic [AVG_BITS:0]             avg_rnd;
   logic [AVG_BITS-Q8_SHIFT:0]    avg_q8;
   logic signed [V_BITS-1:0]      v_in;
   logic                          pct_mode;
   logic                          inverted;
   logic                          empty_range;
   logic signed [LIMIT_BITS-1:0]  lo_sel;
   logic signed [LIMIT_BITS-1:0]  hi_sel;
   logic signed [V_BITS-1:0]      lo256;
   logic signed [V_BITS-1:0]      hi256;
   logic signed [V_BITS-1:0]      v_clamp;
   logic signed [V_BITS-1:0]      num_wide;
   logic [SPAN_BITS-1:0]          span_in;
   logic [NUMER_BITS-1:0]         numer;
   logic [SPAN_BITS:0]            divisor;
   logic [QUO_BITS:0]             trial;
   logic [QUO_BITS:0]             trial_sub;
   logic                          ge;
   logic [QUO_BITS-1:0]           pct_cap;
   logic [QUO_BITS-1:0]           pct_val;
   logic signed [V_BITS-1:0]      v_sat;
   logic signed [RESULT_BITS-1:0] result_in;

   assign rsp_result_q8  = result_ff;
   assign rsp_is_percent = is_percent_ff;

   // Range mode decode; the user must keep the range stable while a word is in flight, the block does not enforce it
   assign pct_mode    = (low_ff != '0) || (high_ff != '0);
   assign inverted    = low_ff > high_ff;
   assign empty_range = (low_ff == high_ff);

   // Start: saturate weight, align sample, decide on a direct load
   assign alpha_sat = (alpha_ff > ONE_Q16) ? ONE_Q16 : alpha_ff;
   assign load      = no_avg_ff || req_restart_filter || (alpha_sat == ONE_Q16);
   assign xs        = AVG_BITS'(req_raw_sample) << AVG_FRAC;
   assign diff_in   = $signed({1'b0, xs}) - $signed({1'b0, avg_ff});

   // Multiply step: two weight bits, most significant first
   always_comb begin
      acc_in = acc_ff <<< 2;
      if (mulb_ff[ALPHA_FRAC-1]) begin
         acc_in = acc_in + (ACC_BITS'(diff_ff) <<< 1);
      end
      if (mulb_ff[ALPHA_FRAC-2]) begin
         acc_in = acc_in + ACC_BITS'(diff_ff);
      end
   end

   // Update: average moves by the rounded weighted difference
   assign acc_rnd = acc_ff + ACC_BITS'(1 << (ALPHA_FRAC - 1));
   assign corr    = acc_rnd >>> ALPHA_FRAC;
   assign avg_in  = avg_ff + corr[AVG_BITS-1:0];

   // Offset reading in Q8
   assign avg_rnd = (AVG_BITS + 1)'(avg_ff) + (AVG_BITS + 1)'(1 << (Q8_SHIFT - 1));
   assign avg_q8  = avg_rnd[AVG_BITS:Q8_SHIFT];
   assign v_in    = V_BITS'(avg_q8) + (V_BITS'(offset_ff) <<< 8);

   // Clamp to the ordered range and form the span
   assign lo_sel   = inverted ? high_ff : low_ff;
   assign hi_sel   = inverted ? low_ff : high_ff;
   assign lo256    = V_BITS'(lo_sel) <<< 8;
   assign hi256    = V_BITS'(hi_sel) <<< 8;
   assign v_clamp  = (v_ff < lo256) ? lo256 : ((v_ff > hi256) ? hi256 : v_ff);
   assign num_wide = v_clamp - lo256;
   assign span_in  = SPAN_BITS'(hi_sel) - SPAN_BITS'(lo_sel);

   // Numerator num*200 + span, divided by 2*span
   assign numer   = (NUMER_BITS'(num_ff) << 7) + (NUMER_BITS'(num_ff) << 6)
                  + (NUMER_BITS'(num_ff) << 3) + NUMER_BITS'(span_ff);
   assign divisor = {span_ff, 1'b0};

   // Restoring divide step
   assign trial     = {rem_ff, qsh_ff[QUO_BITS-1]};
   assign ge        = (QUO_BITS + 2)'(trial) >= (QUO_BITS + 2)'(divisor);
   assign trial_sub = trial - divisor[QUO_BITS:0];

   // Final result selection
   assign pct_cap = (qsh_ff > PCT_FULL) ? PCT_FULL : qsh_ff;
   assign pct_val = inverted ? (PCT_FULL - pct_cap) : pct_cap;
   assign v_sat   = (v_ff > OUT_MAX) ? OUT_MAX : ((v_ff < OUT_MIN) ? OUT_MIN : v_ff);

   always_comb begin
      if (!pct_mode) begin
         result_in = v_sat[RESULT_BITS-1:0];
      end else if (empty_range) begin
         result_in = '0;
      end else begin
         result_in = RESULT_BITS'(pct_val);
      end
   end

   // Configuration and filter control state
   always_ff @(posedge clock) begin
      if (reset) begin
         alpha_ff  <= ONE_Q16;
         low_ff    <= '0;
         high_ff   <= '0;
         offset_ff <= '0;
         no_avg_ff <= 1'b1;
      end else begin
         if (csr_wr_en) begin
            unique case (csr_index_type'(csr_index))
               CSR_EMA_ALPHA:      alpha_ff  <= csr_wdata[ALPHA_BITS-1:0];
               CSR_RANGE_LOW:      low_ff    <= csr_wdata[LIMIT_BITS-1:0];
               CSR_RANGE_HIGH:     high_ff   <= csr_wdata[LIMIT_BITS-1:0];
               CSR_READING_OFFSET: offset_ff <= csr_wdata[OFFSET_BITS-1:0];
               default: ;
            endcase
         end
         if (cmd.start) begin
            no_avg_ff <= 1'b0;
         end
      end
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      if (cmd.start) begin
         diff_ff <= diff_in;
         acc_ff  <= '0;
         if (load) begin
            avg_ff  <= xs;
            mulb_ff <= '0;
         end else begin
            mulb_ff <= alpha_sat[ALPHA_FRAC-1:0];
         end
      end
      if (cmd.mul_step) begin
         acc_ff  <= acc_in;
         mulb_ff <= mulb_ff << 2;
      end
      if (cmd.update) begin
         avg_ff <= avg_in;
      end
      if (cmd.offset) begin
         v_ff <= v_in;
      end
      if (cmd.clamp) begin
         num_ff  <= num_wide[NUM_BITS-1:0];
         span_ff <= span_in;
      end
      if (cmd.div_load) begin
         rem_ff <= numer[NUMER_BITS-1:QUO_BITS];
         qsh_ff <= numer[QUO_BITS-1:0];
      end
      if (cmd.div_step) begin
         rem_ff <= ge ? trial_sub[QUO_BITS-1:0] : trial[QUO_BITS-1:0];
         qsh_ff <= {qsh_ff[QUO_BITS-2:0], ge};
      end
      if (cmd.finish) begin
         result_ff     <= result_in;
         is_percent_ff <= pct_mode;
      end
   end

endmodule

// ===== rtl/ema_sample_to_percent.sv =====
// Channel   Direction  Ports                                   Word
// req       in         req_valid / req_ready                   raw_sample, restart_filter
// rsp       out        rsp_valid / rsp_ready                   result_q8, is_percent
// csr       in         csr_wr_en, csr_index, csr_wdata         one register per write
//
// Each word passes through 8 multiply steps (two weight bits each), four scaling
// steps, 15 steps of the restoring divider and one output load; the next word can be
// taken in the cycle after the result is loaded, so a new word is not taken before
// the previous one has been loaded into the output register.
// Reset clears the configuration to its defaults and marks the average as empty.
// A new word is accepted while the previous result waits in the output register;
// the final load holds until that register is free.
module ema_sample_to_percent (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  logic [esp_pkg::SAMPLE_BITS-1:0]        req_raw_sample,
   input  logic                                   req_restart_filter,
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output logic signed [esp_pkg::RESULT_BITS-1:0] rsp_result_q8,
   output logic                                   rsp_is_percent,
   input  logic                                   csr_wr_en,
   input  logic [esp_pkg::CSR_INDEX_BITS-1:0]     csr_index,
   input  logic [esp_pkg::CSR_DATA_BITS-1:0]      csr_wdata
);
   import esp_pkg::*;

   cmd_type cmd;

   esp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd)
   );

   esp_datapath u_datapath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .csr_wr_en          (csr_wr_en),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata),
      .req_raw_sample     (req_raw_sample),
      .req_restart_filter (req_restart_filter),
      .rsp_result_q8      (rsp_result_q8),
      .rsp_is_percent     (rsp_is_percent)
   );

endmodule

// ===== rtl/esp_checker.sv =====
module esp_checker (
   input logic                                   clock,
   input logic                                   reset,
   input logic                                   req_valid,
   input logic                                   req_ready,
   input logic                                   rsp_valid,
   input logic                                   rsp_ready,
   input logic signed [esp_pkg::RESULT_BITS-1:0] rsp_result_q8,
   input logic                                   rsp_is_percent
);
   import esp_pkg::*;

   // Hold a stalled result word
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_result_q8)
                                  && $stable(rsp_is_percent))
      else $error("result word changed while stalled");

   // Drop ready once a word is taken
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("second word accepted while busy");

   // Keep percent results within the full scale
   a_pct_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_is_percent |-> rsp_result_q8 >= 0
                                      && rsp_result_q8 <= RESULT_BITS'(PCT_FULL))
      else $error("percent result out of range");

   // No result straight out of reset
   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind ema_sample_to_percent esp_checker u_esp_checker (.*);
